// ===== sv/mqf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqf_pkg
// Shared types, constants and a helper function of the message queue bank.
// ----------------------------------------------------------------------------
package mqf_pkg;

    localparam int QUEUE_COUNT    = 8;
    localparam int QUEUE_DEPTH    = 16;
    localparam int ITEM_MAX_BYTES = 4;

    localparam int QID_W   = 4;
    localparam int BYTES_W = 3;
    localparam int DATA_W  = 8 * ITEM_MAX_BYTES;
    localparam int QIDX_W  = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ITEMS   = QUEUE_COUNT * QUEUE_DEPTH;
    localparam int ITEM_AW = $clog2(ITEMS);

    typedef enum logic [1:0] {
        FUNC_CREATE  = 2'd0,
        FUNC_SEND    = 2'd1,
        FUNC_RECEIVE = 2'd2,
        FUNC_UNUSED  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ERROR = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        logic [PTR_W-1:0]   wr_ptr;
        logic [PTR_W-1:0]   rd_ptr;
        logic [FILL_W-1:0]  fill;
        logic [BYTES_W-1:0] size;
    } ctl_t;

    localparam int CTL_W = $bits(ctl_t);

    function automatic logic [DATA_W-1:0] keep_bytes(input logic [DATA_W-1:0] value,
                                                     input logic [BYTES_W-1:0] n);
        logic [DATA_W-1:0] mask;
        unique case (n)
            3'd0:    mask = '0;
            3'd1:    mask = 32'h0000_00FF;
            3'd2:    mask = 32'h0000_FFFF;
            3'd3:    mask = 32'h00FF_FFFF;
            default: mask = '1;
        endcase
        return value & mask;
    endfunction

endpackage

// ===== sv/mqf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqf_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module mqf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/multi_queue_message_fifo_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_queue_message_fifo_top
// Bank of independent circular message queues with create, send and receive
// requests and one result per request.
// ----------------------------------------------------------------------------
// One request is handled at a time. Each request passes through the states
// CTL_RD and EXEC, and a receive also through ITEM_RD, before RESULT; these
// states cover the registered read of the per-queue control memory and, for a
// receive, of the item memory. A result that waits for m_ready holds the
// block in its result state. There is no clearing pass after reset: per-queue
// ready bits mark every queue uncreated.
// ----------------------------------------------------------------------------
module multi_queue_message_fifo_top
    import mqf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_func,
    input  logic [QID_W-1:0]    s_queue_id,
    input  logic [BYTES_W-1:0]  s_item_bytes,
    input  logic [DATA_W-1:0]   s_write_data,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic [DATA_W-1:0]   m_read_data,
    output logic                m_is_empty,
    output logic                m_is_full
);

    typedef enum logic [2:0] {
        IDLE,
        CTL_RD,
        EXEC,
        ITEM_RD,
        RESULT
    } state_t;

    state_t state_reg;

    logic [1:0]         func_reg;
    logic [QID_W-1:0]   qid_reg;
    logic [BYTES_W-1:0] bytes_reg;
    logic [DATA_W-1:0]  wdata_reg;
    logic [BYTES_W-1:0] size_reg;

    logic [QUEUE_COUNT-1:0] ready_reg;

    status_t            res_status_reg;
    logic [DATA_W-1:0]  res_rdata_reg;
    logic               res_empty_reg;
    logic               res_full_reg;

    logic               m_valid_reg;
    status_t            m_status_reg;
    logic [DATA_W-1:0]  m_rdata_reg;
    logic               m_empty_reg;
    logic               m_full_reg;

    logic [QIDX_W-1:0]  qidx;
    logic               qid_ok;
    logic [CTL_W-1:0]   ctl_rdata;
    ctl_t               ctl_cur;
    ctl_t               ctl_new;
    logic               ctl_we;
    logic               create_ok;
    logic [PTR_W-1:0]   slot;
    logic [ITEM_AW-1:0] item_addr;
    logic               item_we;
    logic [DATA_W-1:0]  item_rdata;
    status_t            exec_status;
    logic               exec_recv;

    assign qidx    = qid_reg[QIDX_W-1:0];
    assign qid_ok  = ({1'b0, qid_reg} < (QID_W + 1)'(QUEUE_COUNT));
    assign ctl_cur = (qid_ok && ready_reg[qidx]) ? ctl_t'(ctl_rdata) : '0;

    always_comb begin
        ctl_new     = ctl_cur;
        ctl_we      = 1'b0;
        create_ok   = 1'b0;
        item_we     = 1'b0;
        exec_recv   = 1'b0;
        exec_status = ST_ERROR;
        slot        = ctl_cur.rd_ptr;
        if (qid_ok) begin
            unique case (func_t'(func_reg))
                FUNC_CREATE: begin
                    if ({1'b0, bytes_reg} <= (BYTES_W + 1)'(ITEM_MAX_BYTES)) begin
                        ctl_new     = '0;
                        ctl_new.size = bytes_reg;
                        ctl_we      = 1'b1;
                        create_ok   = 1'b1;
                        exec_status = ST_OK;
                    end
                end
                FUNC_SEND: begin
                    if (ready_reg[qidx]) begin
                        slot = ctl_cur.wr_ptr;
                        if (ctl_cur.fill >= FILL_W'(QUEUE_DEPTH)) begin
                            exec_status = ST_FULL;
                        end else begin
                            ctl_new.wr_ptr = (slot == PTR_W'(QUEUE_DEPTH - 1)) ?
                                             '0 : slot + 1'b1;
                            ctl_new.fill   = ctl_cur.fill + 1'b1;
                            ctl_we         = 1'b1;
                            item_we        = 1'b1;
                            exec_status    = ST_OK;
                        end
                    end
                end
                FUNC_RECEIVE: begin
                    if (ready_reg[qidx]) begin
                        if (ctl_cur.fill == '0) begin
                            exec_status = ST_EMPTY;
                        end else begin
                            ctl_new.rd_ptr = (slot == PTR_W'(QUEUE_DEPTH - 1)) ?
                                             '0 : slot + 1'b1;
                            ctl_new.fill   = ctl_cur.fill - 1'b1;
                            ctl_we         = 1'b1;
                            exec_recv      = 1'b1;
                            exec_status    = ST_OK;
                        end
                    end
                end
                default: begin
                    exec_status = ST_ERROR;
                end
            endcase
        end
    end

    assign item_addr = ITEM_AW'(qidx) * ITEM_AW'(QUEUE_DEPTH) + ITEM_AW'(slot);

    mqf_ram #(
        .WIDTH (CTL_W),
        .DEPTH (QUEUE_COUNT)
    ) u_ctl_ram (
        .aclk  (aclk),
        .we    (state_reg == EXEC && ctl_we),
        .waddr (qidx),
        .wdata (ctl_new),
        .raddr (qidx),
        .rdata (ctl_rdata)
    );

    mqf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ITEMS)
    ) u_item_ram (
        .aclk  (aclk),
        .we    (state_reg == EXEC && item_we),
        .waddr (item_addr),
        .wdata (keep_bytes(wdata_reg, ctl_cur.size)),
        .raddr (item_addr),
        .rdata (item_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            ready_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != RESULT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE: begin
                    if (s_valid) begin
                        func_reg  <= s_func;
                        qid_reg   <= s_queue_id;
                        bytes_reg <= s_item_bytes;
                        wdata_reg <= s_write_data;
                        state_reg <= CTL_RD;
                    end
                end
                CTL_RD: begin
                    state_reg <= EXEC;
                end
                EXEC: begin
                    if (create_ok) begin
                        ready_reg[qidx] <= 1'b1;
                    end
                    size_reg       <= ctl_cur.size;
                    res_status_reg <= exec_status;
                    res_rdata_reg  <= '0;
                    res_empty_reg  <= qid_ok ? (ctl_new.fill == '0) : 1'b1;
                    res_full_reg   <= qid_ok ? (ctl_new.fill >= FILL_W'(QUEUE_DEPTH)) : 1'b0;
                    state_reg      <= exec_recv ? ITEM_RD : RESULT;
                end
                ITEM_RD: begin
                    res_rdata_reg <= keep_bytes(item_rdata, size_reg);
                    state_reg     <= RESULT;
                end
                RESULT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_rdata_reg  <= res_rdata_reg;
                        m_empty_reg  <= res_empty_reg;
                        m_full_reg   <= res_full_reg;
                        state_reg    <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign s_ready     = (state_reg == IDLE);
    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_read_data = m_rdata_reg;
    assign m_is_empty  = m_empty_reg;
    assign m_is_full   = m_full_reg;

endmodule

// ===== sv/mqf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqf_checker
// Port-level checks on the results of the message queue bank.
// ----------------------------------------------------------------------------
module mqf_checker
    import mqf_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [1:0]         m_status,
    input logic [DATA_W-1:0]  m_read_data,
    input logic               m_is_empty,
    input logic               m_is_full
);

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_read_data))
        else $error("Stalled result changed.");

    a_data_only_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_read_data == '0)
        else $error("Read data is nonzero on a failed request.");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_is_empty && m_is_full))
        else $error("Queue reported both empty and full.");

    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_EMPTY |-> m_is_empty)
        else $error("Empty status without empty flag.");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FULL |-> m_is_full)
        else $error("Full status without full flag.");

endmodule

bind multi_queue_message_fifo_top mqf_checker u_mqf_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_read_data (m_read_data),
    .m_is_empty  (m_is_empty),
    .m_is_full   (m_is_full)
);
